>>> sv/nfa_pkg.sv
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared types, widths and codes for the next-fit id allocator.
// ----------------------------------------------------------------------------
package nfa_pkg;

  localparam int NUM_IDS = 64;
  localparam int ID_W    = $clog2(NUM_IDS);
  localparam int CNT_W   = $clog2(NUM_IDS + 1);
  localparam int REQ_W   = 7;
  localparam int GRANT_W = 6;
  localparam int RNG_W   = REQ_W + ID_W;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ILLEGAL   = 3'd1;
  localparam logic [2:0] ST_BUSY      = 3'd2;
  localparam logic [2:0] ST_LIMIT     = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED = 3'd4;

  typedef struct packed {
    logic [1:0]       operation;
    logic             auto_pick;
    logic [REQ_W-1:0] requested_id;
  } nfa_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [GRANT_W-1:0] granted_id;
    logic               occupied;
  } nfa_out_t;

  typedef struct packed {
    logic [ID_W-1:0] cur;
    logic [ID_W-1:0] start;
  } step_req_t;

  typedef struct packed {
    logic [ID_W-1:0] nxt;
    logic            hit_start;
  } step_rsp_t;

endpackage

>>> sv/nfa_ram.sv
// ----------------------------------------------------------------------------
// nfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nfa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/nfa_step.sv
// ----------------------------------------------------------------------------
// nfa_step
// Cursor stepper: advance an id by one, wrap to 1, compare with scan start.
// ----------------------------------------------------------------------------
module nfa_step
  import nfa_pkg::*;
(
  input  step_req_t req,
  output step_rsp_t rsp
);

  logic [ID_W:0]   inc;
  logic [ID_W-1:0] nxt;

  assign inc = {1'b0, req.cur} + (ID_W + 1)'(1);
  assign nxt = (inc >= (ID_W + 1)'(NUM_IDS)) ? ID_W'(1) : inc[ID_W-1:0];

  assign rsp.nxt       = nxt;
  assign rsp.hit_start = (nxt == req.start);

endmodule

>>> sv/next_fit_id_allocator.sv
// ----------------------------------------------------------------------------
// next_fit_id_allocator
// Id slot allocator with requested or next-fit automatic allocation,
// release and occupancy query.
// ----------------------------------------------------------------------------
// One item is worked at a time. Release, query and allocation by id go
// through dispatch, a slot table check and done to a result ready for
// transfer; rejects decided without a table lookup skip the check. An
// automatic allocation walks from the next-fit hint until it finds a free
// slot, or comes back to its start when the table is exhausted: the walk
// reads one slot per cycle through the single read port of the slot table
// and advances through one shared cursor stepper. A finished result waits
// in the output register while the next item is accepted. Slot state
// clears at reset through per-slot valid bits, so no clearing pass is needed.
module next_fit_id_allocator
  import nfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  nfa_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output nfa_out_t out_data
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_CHECK    = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  logic [2:0]       state_r, state_nxt;
  nfa_in_t          req_r, req_nxt;
  logic [ID_W-1:0]  cur_r, cur_nxt;
  logic [ID_W-1:0]  start_r, start_nxt;
  nfa_out_t         res_r, res_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ID_W-1:0]  hint_r, hint_nxt;
  logic             out_valid_r, out_valid_nxt;
  nfa_out_t         out_data_r, out_data_nxt;
  logic [NUM_IDS-1:0] valid_r;
  logic             vld_q_r;

  logic             ram_we;
  logic [ID_W-1:0]  ram_waddr;
  logic [0:0]       ram_wdata;
  logic [ID_W-1:0]  ram_raddr;
  logic [0:0]       ram_rdata;

  step_req_t        step_req;
  step_rsp_t        step_rsp;

  logic             slot_used;
  logic             id_in_range;
  logic             id_zero;
  logic [ID_W-1:0]  id_idx;
  logic             full;
  logic             hint_ok;
  logic [ID_W-1:0]  scan_start;

  nfa_ram #(
    .WIDTH(1),
    .DEPTH(NUM_IDS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nfa_step u_step (
    .req (step_req),
    .rsp (step_rsp)
  );

  assign slot_used   = vld_q_r & ram_rdata[0];
  assign id_in_range = RNG_W'(req_r.requested_id) < RNG_W'(NUM_IDS);
  assign id_zero     = (req_r.requested_id == '0);
  assign id_idx      = ID_W'(req_r.requested_id);
  assign full        = (cnt_r >= CNT_W'(NUM_IDS));
  assign hint_ok     = (hint_r != '0) && ((ID_W + 1)'(hint_r) < (ID_W + 1)'(NUM_IDS));
  assign scan_start  = hint_ok ? hint_r : ID_W'(1);

  assign step_req.cur   = ((state_r == S_SCAN) && slot_used) ? cur_r : hint_r;
  assign step_req.start = start_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cur_nxt       = cur_r;
    start_nxt     = start_r;
    res_nxt       = res_r;
    cnt_nxt       = cnt_r;
    hint_nxt      = hint_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = id_idx;
    ram_wdata     = 1'b0;
    ram_raddr     = cur_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_nxt   = '{status: ST_OK, granted_id: '0, occupied: 1'b0};
        state_nxt = S_DONE;
        unique case (req_r.operation)
          OP_ALLOC: begin
            if (req_r.auto_pick) begin
              if (full) begin
                res_nxt.status = ST_LIMIT;
              end else begin
                cur_nxt   = scan_start;
                start_nxt = scan_start;
                ram_raddr = scan_start;
                state_nxt = S_SCAN;
              end
            end else if (!id_in_range) begin
              res_nxt.status = ST_ILLEGAL;
            end else begin
              ram_raddr = id_idx;
              state_nxt = S_CHECK;
            end
          end
          OP_RELEASE: begin
            if (!id_in_range) begin
              res_nxt.status = ST_ILLEGAL;
            end else begin
              ram_raddr = id_idx;
              state_nxt = S_CHECK;
            end
          end
          OP_QUERY: begin
            if (id_in_range && !id_zero) begin
              ram_raddr = id_idx;
              state_nxt = S_CHECK;
            end
          end
          default: begin
            res_nxt.status = ST_ILLEGAL;
          end
        endcase
      end
      S_CHECK: begin
        state_nxt = S_DONE;
        unique case (req_r.operation)
          OP_ALLOC: begin
            if (slot_used) begin
              res_nxt.status = ST_BUSY;
            end else if (full) begin
              res_nxt.status = ST_LIMIT;
            end else begin
              ram_we             = 1'b1;
              ram_waddr          = id_idx;
              ram_wdata          = 1'b1;
              cnt_nxt            = cnt_r + CNT_W'(1);
              hint_nxt           = step_rsp.nxt;
              res_nxt.granted_id = GRANT_W'(id_idx);
            end
          end
          OP_RELEASE: begin
            if (!slot_used) begin
              res_nxt.status = ST_ILLEGAL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = id_idx;
              ram_wdata = 1'b0;
              if (cnt_r != '0) begin
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
          end
          default: begin
            res_nxt.occupied = slot_used;
          end
        endcase
      end
      S_SCAN: begin
        if (!slot_used) begin
          ram_we             = 1'b1;
          ram_waddr          = cur_r;
          ram_wdata          = 1'b1;
          cnt_nxt            = cnt_r + CNT_W'(1);
          hint_nxt           = step_rsp.nxt;
          res_nxt.granted_id = GRANT_W'(cur_r);
          state_nxt          = S_DONE;
        end else if (step_rsp.hit_start) begin
          res_nxt.status = ST_EXHAUSTED;
          state_nxt      = S_DONE;
        end else begin
          cur_nxt   = step_rsp.nxt;
          ram_raddr = step_rsp.nxt;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      hint_r      <= ID_W'(1);
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cur_r      <= cur_nxt;
    start_r    <= start_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    vld_q_r    <= valid_r[ram_raddr];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NUM_IDS))
    else $error("used count above table size");

  a_hint_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    hint_r != '0)
    else $error("hint pointer at slot zero");

  a_scan_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && !slot_used |=> state_r == S_DONE)
    else $error("free slot found but scan did not finish");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.granted_id != '0) |-> out_data_r.status == ST_OK)
    else $error("granted id on a failed result");

endmodule

>>> bench/next_fit_id_allocator_chk.sv
// ----------------------------------------------------------------------------
// next_fit_id_allocator_chk
// Watches both channels of the id allocator, keeps its own copy of the slot
// table, used count and next-fit hint, works out the reply to every accepted
// request and compares each reply transfer field by field with the oldest
// one still due.
// ----------------------------------------------------------------------------
module next_fit_id_allocator_chk
  import nfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  nfa_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  nfa_out_t out_data,
  output int       errors,
  output int       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [NUM_IDS-1:0] slot_taken;
  int unsigned        taken_count;
  int unsigned        hint;
  nfa_out_t           replies_due[$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  function automatic void take_slot(int unsigned id);
    slot_taken[id] = 1'b1;
    taken_count++;
    hint = (hint + 1 >= NUM_IDS) ? 1 : hint + 1;
  endfunction

  function automatic nfa_out_t resolve_request(nfa_in_t req);
    nfa_out_t    rsp;
    int unsigned id;
    int unsigned cur;
    int unsigned n;
    bit          found;
    rsp   = '0;
    id    = req.requested_id;
    found = 1'b0;
    case (req.operation)
      OP_ALLOC: begin
        if (req.auto_pick) begin
          if (taken_count >= NUM_IDS) begin
            rsp.status = ST_LIMIT;
          end else begin
            cur = (hint >= 1 && hint < NUM_IDS) ? hint : 1;
            n   = 0;
            while (!found && n < NUM_IDS - 1) begin
              if (!slot_taken[cur]) begin
                found = 1'b1;
              end else begin
                cur = (cur + 1 >= NUM_IDS) ? 1 : cur + 1;
                n++;
              end
            end
            if (found) begin
              take_slot(cur);
              rsp.status     = ST_OK;
              rsp.granted_id = GRANT_W'(cur);
            end else begin
              rsp.status = ST_EXHAUSTED;
            end
          end
        end else if (id >= NUM_IDS) begin
          rsp.status = ST_ILLEGAL;
        end else if (slot_taken[id]) begin
          rsp.status = ST_BUSY;
        end else if (taken_count >= NUM_IDS) begin
          rsp.status = ST_LIMIT;
        end else begin
          take_slot(id);
          rsp.status     = ST_OK;
          rsp.granted_id = GRANT_W'(id);
        end
      end
      OP_RELEASE: begin
        if (id >= NUM_IDS || !slot_taken[id]) begin
          rsp.status = ST_ILLEGAL;
        end else begin
          slot_taken[id] = 1'b0;
          if (taken_count > 0) taken_count--;
          rsp.status = ST_OK;
        end
      end
      OP_QUERY: begin
        rsp.status   = ST_OK;
        rsp.occupied = (id >= 1 && id < NUM_IDS) ? slot_taken[id] : 1'b0;
      end
      default: begin
        rsp.status = ST_ILLEGAL;
      end
    endcase
    return rsp;
  endfunction

  task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    nfa_out_t want;
    if (!rst_n) begin
      slot_taken  = '0;
      taken_count = 0;
      hint        = 1;
      replies_due.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          errors++;
          $display("%0t: reply with none due, expected nothing, got status %0d id %0d occ %0d",
                   $time, out_data.status, out_data.granted_id, out_data.occupied);
        end else begin
          want = replies_due.pop_front();
          check_field("status", 8'(want.status), 8'(out_data.status));
          check_field("granted_id", 8'(want.granted_id), 8'(out_data.granted_id));
          check_field("occupied", 8'(want.occupied), 8'(out_data.occupied));
        end
      end
      if (in_valid && in_ready) replies_due.push_back(resolve_request(in_data));
      outstanding <= replies_due.size();
    end
  end

endmodule

>>> bench/next_fit_id_allocator_tb.sv
// ----------------------------------------------------------------------------
// next_fit_id_allocator_tb
// Drives the id allocator with a short directed list of edge cases, then
// random requests that alternate between filling and draining the table,
// under several sender and receiver idle patterns and one long receiver
// hold-off. The checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module next_fit_id_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nfa_pkg::*;

  localparam int         CLK_HALF     = 5;
  localparam int         RESET_CYCLES = 5;
  localparam int         RANDOM_ITEMS = 1050;
  localparam int         PHASES       = 4;
  localparam int         TIDE_LEN     = 60;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         HOLD_ITEMS   = 8;
  localparam int         DRAIN_CYCLES = NUM_IDS + 8;
  localparam int         RUN_LIMIT_NS = 7_000_000;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  nfa_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  nfa_out_t out_data;
  int       faults;
  int       pending;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_asks     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  next_fit_id_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  next_fit_id_allocator_chk chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .errors     (faults),
    .outstanding(pending)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !chance(stall_pct);
    end
  end

  function automatic nfa_in_t make_item(logic [1:0] op, logic pick, int unsigned id);
    nfa_in_t it;
    it.operation    = op;
    it.auto_pick    = pick;
    it.requested_id = REQ_W'(id);
    return it;
  endfunction

  function automatic nfa_in_t pick_item(bit filling);
    nfa_in_t     it;
    int unsigned roll;
    roll            = $urandom_range(99);
    it.auto_pick    = 1'($urandom_range(1));
    it.requested_id = REQ_W'($urandom_range(NUM_IDS - 1));
    if ($urandom_range(9) == 0) it.requested_id = REQ_W'($urandom_range(127));
    if ($urandom_range(15) == 0) it.requested_id = '0;
    if (roll < 2) begin
      it.operation = OP_UNUSED;
    end else if (roll < 14) begin
      it.operation = OP_QUERY;
    end else if (roll < (filling ? 84 : 34)) begin
      it.operation = OP_ALLOC;
      it.auto_pick = ($urandom_range(4) != 0);
    end else begin
      it.operation = OP_RELEASE;
    end
    return it;
  endfunction

  task automatic send_item(nfa_in_t item);
    while (chance(send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    #(RUN_LIMIT_NS);
    $display("next_fit_id_allocator_tb: FAIL");
    $finish;
  end

  initial begin
    nfa_in_t lineup[$];
    int      phase;
    int      k;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    lineup.push_back(make_item(OP_QUERY, 1'b0, 0));
    lineup.push_back(make_item(OP_QUERY, 1'b1, 127));
    lineup.push_back(make_item(OP_RELEASE, 1'b0, 5));
    lineup.push_back(make_item(OP_ALLOC, 1'b0, 127));
    lineup.push_back(make_item(OP_ALLOC, 1'b0, 64));
    lineup.push_back(make_item(OP_ALLOC, 1'b0, 0));
    lineup.push_back(make_item(OP_ALLOC, 1'b0, 0));
    lineup.push_back(make_item(OP_ALLOC, 1'b1, 0));
    lineup.push_back(make_item(OP_ALLOC, 1'b1, 127));
    lineup.push_back(make_item(OP_ALLOC, 1'b0, 63));
    lineup.push_back(make_item(OP_ALLOC, 1'b0, 3));
    lineup.push_back(make_item(OP_ALLOC, 1'b1, 64));
    lineup.push_back(make_item(OP_ALLOC, 1'b0, 3));
    lineup.push_back(make_item(OP_QUERY, 1'b0, 63));
    lineup.push_back(make_item(OP_QUERY, 1'b0, 0));
    lineup.push_back(make_item(OP_QUERY, 1'b0, 1));
    lineup.push_back(make_item(OP_RELEASE, 1'b0, 0));
    lineup.push_back(make_item(OP_RELEASE, 1'b0, 0));
    lineup.push_back(make_item(OP_RELEASE, 1'b1, 64));
    lineup.push_back(make_item(OP_RELEASE, 1'b0, 127));
    lineup.push_back(make_item(OP_RELEASE, 1'b0, 63));
    lineup.push_back(make_item(OP_UNUSED, 1'b1, 127));
    lineup.push_back(make_item(OP_UNUSED, 1'b0, 0));
    lineup.push_back(make_item(OP_ALLOC, 1'b1, 0));
    foreach (lineup[i]) send_item(lineup[i]);
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct <= 0;  end
        1:       begin send_idle_pct = 85; stall_pct <= 0;  end
        2:       begin send_idle_pct = 0;  stall_pct <= 85; end
        default: begin send_idle_pct = 22; stall_pct <= 22; end
      endcase
      for (k = 0; k < RANDOM_ITEMS / PHASES; k++) send_item(pick_item((k / TIDE_LEN) % 2 == 0));
      if (phase == 0) begin
        hold_asks <= hold_asks + 1;
        for (k = 0; k < HOLD_ITEMS; k++) send_item(pick_item(1'b1));
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (faults == 0 && pending == 0) begin
      $display("next_fit_id_allocator_tb: PASS");
    end else begin
      $display("next_fit_id_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule
